[rtl/eba_pkg.sv]
// shared types and constants of the edge blend anti-aliasing filter
package eba_pkg;

  typedef struct packed {
    logic [23:0] pixel_rgb;
    logic        drain;
  } pixel_in_t;

  typedef struct packed {
    logic [23:0] filtered_rgb;
    logic        frame_end;
  } pixel_out_t;

  localparam int unsigned ApbAddrW = 4;

  localparam logic [1:0] RegFrameWidth   = 2'd0;
  localparam logic [1:0] RegFrameHeight  = 2'd1;
  localparam logic [1:0] RegContrastThr  = 2'd2;

  localparam logic [10:0] FrameWidthRst  = 11'd640;
  localparam logic [10:0] FrameHeightRst = 11'd480;
  localparam logic [15:0] ContrastThrRst = 16'd8;

  localparam logic [7:0] LumaCoefR = 8'd77;
  localparam logic [7:0] LumaCoefG = 8'd150;
  localparam logic [7:0] LumaCoefB = 8'd29;

  // luma in 1/256 units, at most 65280
  function automatic logic [15:0] luma_f(logic [23:0] p);
    logic [15:0] r_part;
    logic [15:0] g_part;
    logic [15:0] b_part;
    r_part = {8'd0, LumaCoefR} * {8'd0, p[23:16]};
    g_part = {8'd0, LumaCoefG} * {8'd0, p[15:8]};
    b_part = {8'd0, LumaCoefB} * {8'd0, p[7:0]};
    return r_part + g_part + b_part;
  endfunction

endpackage

[rtl/eba_ram.sv]
// generic simple dual-port ram with registered read
module eba_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/edge_blend_antialias_filter.sv]
// top level of the cross-neighborhood edge blend anti-aliasing filter
//
// pixels enter in raster order on the in channel (valid/ready), results leave on
// the out channel in the same order. output lags one row: pixels of the first
// row give no result, and after frame_height rows the next frame_width requests
// (drain or not, payload ignored) flush the last row, the final one flagged
// frame_end. a drain request outside the flush row is dropped.
// one request is worked on at a time: when the centre passes through, the line
// stores are read (centre and north, then east) and the centre goes out; when
// it is blended, luma, range, an 8-step restoring divider for the blend factor
// and then one channel mix per cycle come before the output.
// the output register frees the next request from the receiver: a new request
// is taken while a result waits; only the next result stalls until it is taken.
// reset clears counters, the west pixel and the handshake; the two line stores
// are not cleared and hold nothing valid until the first row is written.
// the apb port (pready always high) sets width, height and contrast threshold
// and must only be written while the block is idle.
module edge_blend_antialias_filter #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  eba_pkg::pixel_in_t             in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output eba_pkg::pixel_out_t            out_data_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [eba_pkg::ApbAddrW-1:0]   paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  localparam int unsigned ColW = $clog2(MAX_WIDTH);
  localparam int unsigned WdW  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RowW = $clog2(MAX_HEIGHT + 1);

  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StRd1  = 4'd1;
  localparam logic [3:0] StRd2  = 4'd2;
  localparam logic [3:0] StLuma = 4'd3;
  localparam logic [3:0] StStat = 4'd4;
  localparam logic [3:0] StDec  = 4'd5;
  localparam logic [3:0] StDiv  = 4'd6;
  localparam logic [3:0] StMix  = 4'd7;
  localparam logic [3:0] StOut  = 4'd8;

  // configuration
  logic [10:0] width_q, height_q;
  logic [15:0] thr_q;
  logic        cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= eba_pkg::FrameWidthRst;
      height_q <= eba_pkg::FrameHeightRst;
      thr_q    <= eba_pkg::ContrastThrRst;
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        eba_pkg::RegFrameWidth:  width_q  <= pwdata[10:0];
        eba_pkg::RegFrameHeight: height_q <= pwdata[10:0];
        eba_pkg::RegContrastThr: thr_q    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      eba_pkg::RegFrameWidth:  prdata = {21'd0, width_q};
      eba_pkg::RegFrameHeight: prdata = {21'd0, height_q};
      eba_pkg::RegContrastThr: prdata = {16'd0, thr_q};
      default:                 prdata = 32'd0;
    endcase
  end

  // clamped frame size
  logic [31:0] wd32, ht32;
  logic [WdW-1:0]  wd;
  logic [RowW-1:0] ht;

  always_comb begin
    wd32 = {21'd0, width_q};
    if (wd32 < 32'd3) wd32 = 32'd3;
    if (wd32 > 32'(MAX_WIDTH)) wd32 = 32'(MAX_WIDTH);
    ht32 = {21'd0, height_q};
    if (ht32 < 32'd3) ht32 = 32'd3;
    if (ht32 > 32'(MAX_HEIGHT)) ht32 = 32'(MAX_HEIGHT);
    wd = wd32[WdW-1:0];
    ht = ht32[RowW-1:0];
  end

  // control and datapath registers
  logic [3:0]      state_q, state_d;
  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  logic [RowW-1:0] cur_row_q, cur_row_d;
  logic            flush_q, flush_d;
  logic [23:0]     west_q, west_d;
  logic [23:0]     pix_q, pix_d;
  logic [23:0]     centre_q, centre_d;
  logic [23:0]     north_q, north_d;
  logic [23:0]     east_q, east_d;
  logic [15:0]     lm_q, ln_q, le_q, ls_q, lw_q;
  logic [15:0]     lm_d, ln_d, le_d, ls_d, lw_d;
  logic [15:0]     range_q, range_d;
  logic [17:0]     diff_q, diff_d;
  logic [8:0]      blend_q, blend_d;
  logic [15:0]     rem_q, rem_d;
  logic [7:0]      num_q, num_d;
  logic [7:0]      quo_q, quo_d;
  logic [2:0]      step_q, step_d;
  logic [1:0]      ch_q, ch_d;
  logic [23:0]     res_q, res_d;
  logic            out_valid_q, out_valid_d;
  eba_pkg::pixel_out_t out_q, out_d;

  // line stores
  logic [23:0]     above_rdata, two_rdata;
  logic [ColW-1:0] above_raddr;
  logic            store_we;

  assign store_we    = (state_q == StRd1);
  assign above_raddr = (state_q == StIdle) ? col_q : ColW'({1'b0, col_q} + 1'b1);

  eba_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_row_above (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (col_q),
    .wdata_i (pix_q),
    .raddr_i (above_raddr),
    .rdata_o (above_rdata)
  );

  eba_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_two_rows_above (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (col_q),
    .wdata_i (above_rdata),
    .raddr_i (col_q),
    .rdata_o (two_rdata)
  );

  // helpers
  logic [ColW:0] col_inc;
  logic          col_wrap;
  logic          blend_en;
  logic          in_acc;
  logic          emit;
  logic          load_out;
  logic          frame_end_d;
  logic [15:0]   mn, mx;
  logic [17:0]   sum4, lm4;
  logic [16:0]   div_t;
  logic          div_bit;
  logic [7:0]    m_ch, n_ch, e_ch, s_ch, w_ch;
  logic [9:0]    sum_ch;
  logic [8:0]    inv_blend;
  logic [18:0]   mix_a, mix_b;
  logic [19:0]   mix_tot;

  assign in_ready_o = (state_q == StIdle);
  assign in_acc     = in_valid_i & in_ready_o;
  assign col_inc    = {1'b0, col_q} + 1'b1;
  assign col_wrap   = 32'(col_inc) >= 32'(wd);
  assign blend_en   = (cur_row_q >= RowW'(2)) && (32'(cur_row_q) + 32'd1 <= 32'(ht)) &&
                      (col_q != '0) && (32'(col_inc) < 32'(wd));
  assign emit        = (cur_row_q != '0);
  assign frame_end_d = flush_q & col_wrap;
  assign load_out    = (state_q == StOut) && emit && (!out_valid_q || out_ready_i);

  always_comb begin
    // neighbor luma statistics, north repeated as the seed
    mn = ln_q;
    mx = ln_q;
    if (le_q < mn) mn = le_q;
    if (le_q > mx) mx = le_q;
    if (ls_q < mn) mn = ls_q;
    if (ls_q > mx) mx = ls_q;
    if (lw_q < mn) mn = lw_q;
    if (lw_q > mx) mx = lw_q;
    sum4 = {2'b0, ln_q} + {2'b0, le_q} + {2'b0, ls_q} + {2'b0, lw_q};
    lm4  = {lm_q, 2'b00};

    div_t   = {rem_q, num_q[7]};
    div_bit = div_t >= {1'b0, range_q};

    unique case (ch_q)
      2'd0: begin
        m_ch = centre_q[23:16]; n_ch = north_q[23:16]; e_ch = east_q[23:16];
        s_ch = pix_q[23:16];    w_ch = west_q[23:16];
      end
      2'd1: begin
        m_ch = centre_q[15:8]; n_ch = north_q[15:8]; e_ch = east_q[15:8];
        s_ch = pix_q[15:8];    w_ch = west_q[15:8];
      end
      default: begin
        m_ch = centre_q[7:0]; n_ch = north_q[7:0]; e_ch = east_q[7:0];
        s_ch = pix_q[7:0];    w_ch = west_q[7:0];
      end
    endcase
    sum_ch    = {2'b0, n_ch} + {2'b0, e_ch} + {2'b0, s_ch} + {2'b0, w_ch};
    inv_blend = 9'd256 - blend_q;
    mix_a     = 19'(inv_blend) * 19'({m_ch, 2'b00});
    mix_b     = 19'(blend_q) * 19'(sum_ch);
    mix_tot   = {1'b0, mix_a} + {1'b0, mix_b};
  end

  always_comb begin
    state_d     = state_q;
    col_d       = col_q;
    row_d       = row_q;
    cur_row_d   = cur_row_q;
    flush_d     = flush_q;
    west_d      = west_q;
    pix_d       = pix_q;
    centre_d    = centre_q;
    north_d     = north_q;
    east_d      = east_q;
    lm_d        = lm_q;
    ln_d        = ln_q;
    le_d        = le_q;
    ls_d        = ls_q;
    lw_d        = lw_q;
    range_d     = range_q;
    diff_d      = diff_q;
    blend_d     = blend_q;
    rem_d       = rem_q;
    num_d       = num_q;
    quo_d       = quo_q;
    step_d      = step_q;
    ch_d        = ch_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          if (row_q >= ht) begin
            flush_d   = 1'b1;
            pix_d     = 24'd0;
            cur_row_d = ht;
            state_d   = StRd1;
          end else if (!in_data_i.drain) begin
            flush_d   = 1'b0;
            pix_d     = in_data_i.pixel_rgb;
            cur_row_d = row_q;
            state_d   = StRd1;
          end
        end
      end
      StRd1: begin
        centre_d = above_rdata;
        north_d  = two_rdata;
        state_d  = StRd2;
      end
      StRd2: begin
        east_d = above_rdata;
        if (blend_en) begin
          state_d = StLuma;
        end else begin
          res_d   = centre_q;
          state_d = StOut;
        end
      end
      StLuma: begin
        lm_d    = eba_pkg::luma_f(centre_q);
        ln_d    = eba_pkg::luma_f(north_q);
        le_d    = eba_pkg::luma_f(east_q);
        ls_d    = eba_pkg::luma_f(pix_q);
        lw_d    = eba_pkg::luma_f(west_q);
        state_d = StStat;
      end
      StStat: begin
        range_d = mx - mn;
        diff_d  = (sum4 > lm4) ? sum4 - lm4 : lm4 - sum4;
        state_d = StDec;
      end
      StDec: begin
        ch_d = 2'd0;
        priority if (range_q < thr_q) begin
          res_d   = centre_q;
          state_d = StOut;
        end else if (diff_q == '0) begin
          blend_d = 9'd0;
          state_d = StMix;
        end else if (diff_q >= {range_q, 2'b00}) begin
          blend_d = 9'd256;
          state_d = StMix;
        end else begin
          // quotient of diff*64 / range, known to be below 256
          rem_d   = diff_q[17:2];
          num_d   = {diff_q[1:0], 6'd0};
          quo_d   = 8'd0;
          step_d  = 3'd7;
          state_d = StDiv;
        end
      end
      StDiv: begin
        rem_d = div_bit ? 16'(div_t - {1'b0, range_q}) : div_t[15:0];
        num_d = {num_q[6:0], 1'b0};
        quo_d = {quo_q[6:0], div_bit};
        if (step_q == 3'd0) begin
          blend_d = {1'b0, quo_q[6:0], div_bit};
          ch_d    = 2'd0;
          state_d = StMix;
        end else begin
          step_d = step_q - 3'd1;
        end
      end
      StMix: begin
        unique case (ch_q)
          2'd0:    res_d[23:16] = mix_tot[17:10];
          2'd1:    res_d[15:8]  = mix_tot[17:10];
          default: res_d[7:0]   = mix_tot[17:10];
        endcase
        if (ch_q == 2'd2) begin
          state_d = StOut;
        end else begin
          ch_d = ch_q + 2'd1;
        end
      end
      StOut: begin
        if (!emit || !out_valid_q || out_ready_i) begin
          if (emit) begin
            out_valid_d        = 1'b1;
            out_d.filtered_rgb = res_q;
            out_d.frame_end    = frame_end_d;
          end
          west_d = centre_q;
          if (col_wrap) begin
            col_d = '0;
            row_d = flush_q ? '0 : cur_row_q + RowW'(1);
          end else begin
            col_d = col_inc[ColW-1:0];
            row_d = cur_row_q;
          end
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      col_q       <= '0;
      row_q       <= '0;
      cur_row_q   <= '0;
      flush_q     <= 1'b0;
      west_q      <= 24'd0;
      step_q      <= 3'd0;
      ch_q        <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      col_q       <= col_d;
      row_q       <= row_d;
      cur_row_q   <= cur_row_d;
      flush_q     <= flush_d;
      west_q      <= west_d;
      step_q      <= step_d;
      ch_q        <= ch_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pix_q    <= pix_d;
    centre_q <= centre_d;
    north_q  <= north_d;
    east_q   <= east_d;
    lm_q     <= lm_d;
    ln_q     <= ln_d;
    le_q     <= le_d;
    ls_q     <= ls_d;
    lw_q     <= lw_d;
    range_q  <= range_d;
    diff_q   <= diff_d;
    blend_q  <= blend_d;
    rem_q    <= rem_d;
    num_q    <= num_d;
    quo_q    <= quo_d;
    res_q    <= res_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_ready_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> !in_ready_o)
    else $error("request taken while a pixel is in progress");

  a_blend_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StMix) |-> (blend_q <= 9'd256))
    else $error("blend factor above unity");

  a_div_rem_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDiv) |-> (rem_q < range_q))
    else $error("divider remainder not below the range");

  a_frame_end_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && frame_end_d) |=> (row_q == '0 && col_q == '0))
    else $error("counters not cleared after frame end");
`endif

endmodule
